>>> rtl/core/nvd_pkg.sv
// ----------------------------------------------------------------------------
// nvd_pkg
// Shared types and constants of the nibble varint decoder.
// ----------------------------------------------------------------------------
package nvd_pkg;

    localparam int unsigned ValueWidth = 64;
    localparam int unsigned UsedWidth  = 4;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned NibWidth   = 4;
    localparam logic [3:0]  MaxCount   = 4'd9;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADCOUNT = 2'd1,
        ST_MISSING  = 2'd2,
        ST_NODATA   = 2'd3
    } t_status;

    typedef struct packed {
        logic [ValueWidth-1:0] value;
        logic [UsedWidth-1:0]  used;
        t_status               status;
    } t_result;

endpackage

>>> rtl/core/nvd_in_stage.sv
// ----------------------------------------------------------------------------
// nvd_in_stage
// Input register slice: captures one transaction and holds it until decode.
// ----------------------------------------------------------------------------
module nvd_in_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [nvd_pkg::ByteWidth-1:0]  i_byte,
    input  logic                           i_end,
    input  logic                           i_adv,
    output logic                           o_valid,
    output logic [nvd_pkg::ByteWidth-1:0]  o_byte,
    output logic                           o_end
);

    logic                          r_valid;
    logic [nvd_pkg::ByteWidth-1:0] r_byte;
    logic                          r_end;

    assign o_ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
            r_end  <= i_end;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_end   = r_end;

endmodule

>>> rtl/core/nvd_decode.sv
// ----------------------------------------------------------------------------
// nvd_decode
// Header check, nibble accumulation and value completion, one byte a cycle.
// ----------------------------------------------------------------------------
module nvd_decode (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [nvd_pkg::ByteWidth-1:0]  i_byte,
    input  logic                           i_end,
    output logic                           o_res_valid,
    output nvd_pkg::t_result               o_res
);

    logic [nvd_pkg::ValueWidth-1:0] r_accum;
    logic [nvd_pkg::ValueWidth-1:0] n_accum;
    logic [nvd_pkg::UsedWidth-1:0]  r_expected;
    logic [nvd_pkg::UsedWidth-1:0]  n_expected;
    logic [nvd_pkg::UsedWidth-1:0]  r_seen;
    logic [nvd_pkg::UsedWidth-1:0]  n_seen;

    logic [nvd_pkg::NibWidth-1:0]   hi_nib;
    logic [nvd_pkg::NibWidth-1:0]   lo_nib;
    logic [6:0]                     sh_lo;
    logic [6:0]                     sh_hi;
    logic [nvd_pkg::ValueWidth-1:0] acc_next;
    logic [nvd_pkg::UsedWidth-1:0]  seen_inc;

    assign hi_nib   = i_byte[7:4];
    assign lo_nib   = i_byte[3:0];
    assign sh_lo    = {r_seen, 3'b000};
    assign sh_hi    = sh_lo - 7'd4;
    assign acc_next = r_accum
                    | (nvd_pkg::ValueWidth'(hi_nib) << sh_hi)
                    | (nvd_pkg::ValueWidth'(lo_nib) << sh_lo);
    assign seen_inc = r_seen + 4'd1;

    always_comb begin
        n_accum     = r_accum;
        n_expected  = r_expected;
        n_seen      = r_seen;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_valid) begin
            if (i_end) begin
                n_accum     = '0;
                n_expected  = '0;
                n_seen      = '0;
                o_res_valid = 1'b1;
                o_res.status = (r_expected == '0) ? nvd_pkg::ST_NODATA
                                                  : nvd_pkg::ST_MISSING;
            end else if (r_expected == '0) begin
                if (i_byte == '0) begin
                    o_res_valid = 1'b1;
                    o_res.used  = 4'd1;
                end else if (hi_nib == '0 || hi_nib > nvd_pkg::MaxCount) begin
                    o_res_valid  = 1'b1;
                    o_res.status = nvd_pkg::ST_BADCOUNT;
                end else if (hi_nib == 4'd1) begin
                    o_res_valid = 1'b1;
                    o_res.value = nvd_pkg::ValueWidth'(lo_nib);
                    o_res.used  = 4'd1;
                end else begin
                    n_accum    = nvd_pkg::ValueWidth'(lo_nib);
                    n_expected = hi_nib;
                    n_seen     = 4'd1;
                end
            end else if (seen_inc >= r_expected) begin
                o_res_valid = 1'b1;
                o_res.value = acc_next;
                o_res.used  = r_expected;
                n_accum     = '0;
                n_expected  = '0;
                n_seen      = '0;
            end else begin
                n_accum = acc_next;
                n_seen  = seen_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum    <= '0;
            r_expected <= '0;
            r_seen     <= '0;
        end else begin
            r_accum    <= n_accum;
            r_expected <= n_expected;
            r_seen     <= n_seen;
        end
    end

endmodule

>>> rtl/core/nvd_out_stage.sv
// ----------------------------------------------------------------------------
// nvd_out_stage
// Result register: holds a finished result until the transaction completes.
// ----------------------------------------------------------------------------
module nvd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  nvd_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output nvd_pkg::t_result o_res
);

    logic             r_valid;
    nvd_pkg::t_result r_res;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> rtl/core/nibble_varint_u64_decoder_unit.sv
// ----------------------------------------------------------------------------
// nibble_varint_u64_decoder_unit
// Decodes nibble-coded variable-length unsigned 64-bit values from a byte
// stream.
// ----------------------------------------------------------------------------
// Takes one byte (or a stream-end marker) per cycle at full rate while the
// result sink accepts; a stalled result register holds off the input. Each
// transaction passes an input register, then one pass of header check and
// nibble insertion into the accumulator, and lands in the result register.
// The accumulator update sets the rate of one byte per clock.
// ----------------------------------------------------------------------------
module nibble_varint_u64_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tuser,   // [0] stream_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [63:0] decoded_value, [67:64] used_bytes, zero pad
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    logic             in_valid;
    logic [7:0]       in_byte;
    logic             in_end;
    logic             out_free;
    logic             adv;
    logic             res_valid;
    nvd_pkg::t_result res;
    nvd_pkg::t_result out_res;

    assign adv = in_valid && out_free;

    nvd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .i_end   (i_s_tuser),
        .i_adv   (adv),
        .o_valid (in_valid),
        .o_byte  (in_byte),
        .o_end   (in_end)
    );

    nvd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (adv),
        .i_byte      (in_byte),
        .i_end       (in_end),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    nvd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_ready (i_m_tready),
        .o_free  (out_free),
        .o_valid (o_m_tvalid),
        .o_res   (out_res)
    );

    assign o_m_tdata = {4'b0000, out_res.used, out_res.value};
    assign o_m_tuser = out_res.status;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_ok_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == nvd_pkg::ST_OK)
            |-> (o_m_tdata[67:64] != 4'd0 && o_m_tdata[67:64] <= nvd_pkg::MaxCount))
        else $error("ok result with bad used byte count");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != nvd_pkg::ST_OK)
            |-> (o_m_tdata[67:0] == 68'd0))
        else $error("error result carries nonzero value or count");

    a_single_nib: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[67:64] == 4'd1) |-> (o_m_tdata[63:4] == 60'd0))
        else $error("one-byte value wider than a nibble");

endmodule

>>> dv/tb_nibble_varint_u64_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_nibble_varint_u64_decoder_unit
// Self-checking bench for the nibble varint decoder: a scoreboard decodes each
// accepted byte or stream-end marker in lockstep with the block, queues the
// decoded value it predicts and compares every result transaction, field by
// field, under several source-idle and sink-stall mixes and one long sink hold.
// ----------------------------------------------------------------------------
module tb_nibble_varint_u64_decoder_unit;

    localparam int unsigned HoldCycles = 300;
    localparam int unsigned PhaseItems = 440;

    class varint_scoreboard;
        logic [nvd_pkg::ValueWidth-1:0] accum;
        logic [3:0]                     want_bytes;
        logic [3:0]                     got_bytes;
        nvd_pkg::t_result               decoded_q[$];
        int unsigned                    mismatches;

        function new();
            accum      = '0;
            want_bytes = '0;
            got_bytes  = '0;
            mismatches = 0;
        endfunction

        function void queue_value(logic [nvd_pkg::ValueWidth-1:0] v, logic [3:0] used,
                                  nvd_pkg::t_status st);
            nvd_pkg::t_result r;
            r.value  = v;
            r.used   = used;
            r.status = st;
            decoded_q.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b, logic eos);
            logic [3:0]  cnt;
            int unsigned pos;
            cnt = b[7:4];
            if (eos) begin
                queue_value('0, '0, (want_bytes == 0) ? nvd_pkg::ST_NODATA
                                                      : nvd_pkg::ST_MISSING);
                accum      = '0;
                want_bytes = '0;
                got_bytes  = '0;
            end else if (want_bytes == 0) begin
                if (b == 8'h00) begin
                    queue_value('0, 4'd1, nvd_pkg::ST_OK);
                end else if (cnt == 0 || cnt > nvd_pkg::MaxCount) begin
                    queue_value('0, '0, nvd_pkg::ST_BADCOUNT);
                end else if (cnt == 1) begin
                    queue_value({60'd0, b[3:0]}, 4'd1, nvd_pkg::ST_OK);
                end else begin
                    accum      = {60'd0, b[3:0]};
                    want_bytes = cnt;
                    got_bytes  = 4'd1;
                end
            end else begin
                pos = 2 * got_bytes - 1;
                if (pos < 16) accum[4*pos +: 4] = accum[4*pos +: 4] | b[7:4];
                pos = 2 * got_bytes;
                if (pos < 16) accum[4*pos +: 4] = accum[4*pos +: 4] | b[3:0];
                got_bytes = got_bytes + 4'd1;
                if (got_bytes >= want_bytes) begin
                    queue_value(accum, want_bytes, nvd_pkg::ST_OK);
                    accum      = '0;
                    want_bytes = '0;
                    got_bytes  = '0;
                end
            end
        endfunction

        function void check_value(logic [71:0] tdata, logic [1:0] tuser);
            nvd_pkg::t_result exp;
            if (decoded_q.size() == 0) begin
                $error("result transaction with nothing expected: value %0h used %0d status %0d",
                       tdata[63:0], tdata[67:64], tuser);
                mismatches++;
                return;
            end
            exp = decoded_q.pop_front();
            if (tdata[63:0] !== exp.value) begin
                $error("decoded_value: expected %0h, actual %0h", exp.value, tdata[63:0]);
                mismatches++;
            end
            if (tdata[67:64] !== exp.used) begin
                $error("used_bytes: expected %0d, actual %0d", exp.used, tdata[67:64]);
                mismatches++;
            end
            if (tuser !== exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, tuser);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = '0;   // [7:0] in_byte
    logic        i_s_tuser  = 1'b0; // [0] stream_end
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;         // [63:0] decoded_value, [67:64] used_bytes, zero pad
    logic [1:0]  o_m_tuser;         // [1:0] status

    varint_scoreboard sb;
    int unsigned      src_idle_pct = 0;
    int unsigned      snk_stall_pct = 0;
    int unsigned      n_sent = 0;
    logic            hold_tgl = 1'b0;
    logic            hold_seen = 1'b0;
    int unsigned      hold_left = 0;

    nibble_varint_u64_decoder_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        hold_seen <= hold_tgl;
        if (hold_left != 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (hold_tgl != hold_seen) begin
            i_m_tready <= 1'b0;
            hold_left  <= HoldCycles;
        end else begin
            i_m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_value(o_m_tdata, o_m_tuser);
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= eos;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_byte(b, eos);
        n_sent++;
    endtask

    // one encoded value with random content, or a stray byte or stream end
    task automatic send_value();
        int unsigned r;
        int unsigned cnt;
        int unsigned i;
        logic [7:0]  hdr;
        r   = $urandom_range(99);
        cnt = $urandom_range(9, 1);
        hdr = {cnt[3:0], 4'($urandom_range(15))};
        if (r < 4) begin
            send_byte(8'($urandom), 1'b1);
        end else if (r < 12) begin
            send_byte(8'($urandom_range(255)), 1'b0);
        end else if (r < 16) begin
            send_byte(8'h00, 1'b0);
        end else begin
            send_byte(hdr, 1'b0);
            for (i = 1; i < cnt; i++) begin
                if ($urandom_range(99) < 3) begin
                    send_byte(8'($urandom), 1'b1);
                    break;
                end
                send_byte(8'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    initial begin
        int unsigned phase;
        int unsigned goal;
        int unsigned i;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(8'h00, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h2A, 1'b0);
        send_byte(8'hBC, 1'b0);
        send_byte(8'h9F, 1'b0);
        for (i = 0; i < 8; i++) send_byte(8'hFF, 1'b0);
        send_byte(8'h35, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h21, 1'b0);
        send_byte(8'h00, 1'b0);

        goal = n_sent;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                    hold_tgl     <= ~hold_tgl;
                end
                1: begin
                    src_idle_pct  = 65;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 65;
                end
                default: begin
                    src_idle_pct  = 31;
                    snk_stall_pct = 31;
                end
            endcase
            goal += PhaseItems;
            while (n_sent < goal) send_value();
        end
        i_s_tvalid <= 1'b0;

        while (sb.decoded_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("nibble_varint_u64_decoder_unit: match");
        end else begin
            $display("nibble_varint_u64_decoder_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("nibble_varint_u64_decoder_unit: mismatch");
        $finish;
    end

endmodule
